### rtl/drld_pkg.sv
`timescale 1ns / 1ps

package drld_pkg;

	// Widest length or start field, in bytes
	localparam int MAX_FIELD_BYTES = 4;
	// Width of the running cluster position
	localparam int POSITION_BITS = 48;

	localparam int CNT_W = $clog2(MAX_FIELD_BYTES + 1);
	localparam int ACC_W = 8 * MAX_FIELD_BYTES;
	// Signed sum of position and delta, with room for sign and carry
	localparam int SUM_W = ((POSITION_BITS > ACC_W) ? POSITION_BITS : ACC_W) + 2;

	localparam int STATUS_W    = 3;
	localparam int RUN_START_W = 48;
	localparam int RUN_LEN_W   = 32;

	typedef enum logic [STATUS_W-1:0] {
		ST_RUN       = 3'd0,
		ST_END       = 3'd1,
		ST_BAD_LEN   = 3'd2,
		ST_BAD_START = 3'd3,
		ST_NEGATIVE  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_LENGTH = 2'd1,
		PH_START  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       list_start;
	} in_t;

	typedef struct packed {
		status_t                status;
		logic [RUN_START_W-1:0] run_start;
		logic [RUN_LEN_W-1:0]   run_length;
		logic [RUN_START_W-1:0] run_last;
	} out_t;

endpackage

### rtl/data_run_list_decoder_core.sv
`timescale 1ns / 1ps

// Run-list decoder: takes the bytes of an extent run list, one request per byte,
// and returns one result request per decoded run or list event.
// Input channel  : in_valid / in_ready, payload in_data (data_byte, list_start).
//                  Set list_start on the header byte that opens a new list; this
//                  clears the running position and any halt from a previous list.
// Output channel : out_valid / out_ready, payload out_data (status, run_start,
//                  run_length, run_last). Bytes inside a run give no result.
// Configuration  : cfg_we / cfg_wdata write relative_offsets (reset 1); write
//                  only while the block is idle.
// Pipeline       : a result passes the input register, the decode/position
//                  register and the end-cluster register, in that order.
// Throughput     : one byte per cycle unless the output stalls; the decode and position
//                  update of a byte are combinational between input and result registers.
// Stall          : the three stages advance independently, so bubbles close up;
//                  in_ready drops only once every stage holds a request.
// Reset          : arst_n clears all control state, puts the decoder in the
//                  header phase with position zero and selects relative mode.
module data_run_list_decoder_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  drld_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output drld_pkg::out_t  out_data,
	input  logic            cfg_we,
	input  logic            cfg_wdata
);

	// ------------------------------------------------------------------
	// Pipeline registers and handshake
	// ------------------------------------------------------------------
	logic                              v_s1;
	drld_pkg::in_t                     in_s1;
	logic                              v_s2;
	drld_pkg::status_t                 status_s2;
	logic [drld_pkg::POSITION_BITS-1:0] start_s2;
	logic [drld_pkg::RUN_LEN_W-1:0]    len_s2;
	logic [drld_pkg::RUN_LEN_W-1:0]    lenm1_s2;
	logic                              out_valid_q;
	drld_pkg::out_t                    out_q;

	logic adv_out;
	logic adv_s2;
	logic fire_s1;

	// Decoder state
	logic                               rel_q;
	drld_pkg::phase_t                   phase_q;
	logic [drld_pkg::CNT_W-1:0]         bytes_left_q;
	logic [drld_pkg::CNT_W-1:0]         length_size_q;
	logic [drld_pkg::CNT_W-1:0]         start_size_q;
	logic [drld_pkg::ACC_W-1:0]         len_acc_q;
	logic [drld_pkg::ACC_W-1:0]         start_acc_q;
	logic [drld_pkg::POSITION_BITS-1:0] position_q;
	logic                               halted_q;

	// Next state
	drld_pkg::phase_t                   phase_d;
	logic [drld_pkg::CNT_W-1:0]         bytes_left_d;
	logic [drld_pkg::CNT_W-1:0]         length_size_d;
	logic [drld_pkg::CNT_W-1:0]         start_size_d;
	logic [drld_pkg::ACC_W-1:0]         len_acc_d;
	logic [drld_pkg::ACC_W-1:0]         start_acc_d;
	logic [drld_pkg::POSITION_BITS-1:0] position_d;
	logic                               halted_d;

	// Decode datapath
	logic                               ls;
	drld_pkg::phase_t                   phase_e;
	logic                               halted_e;
	logic [drld_pkg::POSITION_BITS-1:0] pos_e;
	logic [7:0]                         b;
	logic [3:0]                         len_nib;
	logic [3:0]                         st_nib;
	logic                               bad_len;
	logic                               bad_st;
	logic                               last_byte;
	logic [drld_pkg::CNT_W-1:0]         k_len;
	logic [drld_pkg::CNT_W-1:0]         k_st;
	logic [drld_pkg::ACC_W-1:0]         len_acc_n;
	logic [drld_pkg::ACC_W-1:0]         start_acc_n;
	logic                               delta_sign;
	logic [drld_pkg::SUM_W-1:0]         delta_ext;
	logic [drld_pkg::SUM_W-1:0]         abs_ext;
	logic [drld_pkg::SUM_W-1:0]         pos_sum;
	logic                               pos_neg;
	logic [drld_pkg::POSITION_BITS-1:0] new_start;
	logic [drld_pkg::RUN_LEN_W-1:0]     run_len;

	logic                               res_valid;
	drld_pkg::status_t                  res_status;
	logic [drld_pkg::POSITION_BITS-1:0] res_start;
	logic [drld_pkg::RUN_LEN_W-1:0]     res_len;

	// End-cluster stage
	logic [drld_pkg::POSITION_BITS:0]   last_sum;
	logic [drld_pkg::POSITION_BITS-1:0] run_last;

	// Each stage advances when the one after it is empty or advancing
	assign adv_out  = !out_valid_q || out_ready;
	assign adv_s2   = !v_s2 || adv_out;
	assign in_ready = !v_s1 || adv_s2;
	assign fire_s1  = v_s1 && adv_s2;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// ------------------------------------------------------------------
	// Effective state for the byte in s1: a list start wipes position,
	// halt and phase before the byte is decoded
	// ------------------------------------------------------------------
	assign ls       = in_s1.list_start;
	assign phase_e  = ls ? drld_pkg::PH_HEADER : phase_q;
	assign halted_e = ls ? 1'b0 : halted_q;
	assign pos_e    = ls ? '0 : position_q;
	assign b        = in_s1.data_byte;
	assign len_nib  = b[3:0];
	assign st_nib   = b[7:4];
	assign bad_len  = (len_nib == 4'd0) || (len_nib > 4'(drld_pkg::MAX_FIELD_BYTES));
	assign bad_st   = (st_nib == 4'd0) || (st_nib > 4'(drld_pkg::MAX_FIELD_BYTES));
	assign last_byte = (bytes_left_q == drld_pkg::CNT_W'(1));
	assign k_len    = length_size_q - bytes_left_q;
	assign k_st     = start_size_q - bytes_left_q;
	assign run_len  = drld_pkg::RUN_LEN_W'(len_acc_q);

	// Merge the incoming byte into its lane of each accumulator
	always_comb begin
		len_acc_n   = len_acc_q;
		start_acc_n = start_acc_q;
		for (int i = 0; i < drld_pkg::MAX_FIELD_BYTES; i++) begin
			if (k_len == drld_pkg::CNT_W'(i)) begin
				len_acc_n[8*i +: 8] = len_acc_q[8*i +: 8] | b;
			end
			if (k_st == drld_pkg::CNT_W'(i)) begin
				start_acc_n[8*i +: 8] = start_acc_q[8*i +: 8] | b;
			end
		end
	end

	// Sign-extend the start delta from its byte size and add it to position
	always_comb begin
		delta_sign = 1'b0;
		for (int i = 0; i < drld_pkg::MAX_FIELD_BYTES; i++) begin
			if (start_size_q == drld_pkg::CNT_W'(i + 1)) begin
				delta_sign = start_acc_n[8*i + 7];
			end
		end
		delta_ext = {drld_pkg::SUM_W{delta_sign}};
		for (int i = 0; i < drld_pkg::MAX_FIELD_BYTES; i++) begin
			if (drld_pkg::CNT_W'(i) < start_size_q) begin
				delta_ext[8*i +: 8] = start_acc_n[8*i +: 8];
			end
		end
	end

	assign abs_ext   = drld_pkg::SUM_W'(start_acc_n);
	assign pos_sum   = drld_pkg::SUM_W'(pos_e) + delta_ext;
	// Only a negative delta can drive the sum below zero
	assign pos_neg   = pos_sum[drld_pkg::SUM_W-1];
	assign new_start = rel_q ? pos_sum[drld_pkg::POSITION_BITS-1:0]
	                         : abs_ext[drld_pkg::POSITION_BITS-1:0];

	// ------------------------------------------------------------------
	// Next state of the decoder
	// ------------------------------------------------------------------
	always_comb begin
		phase_d       = phase_q;
		bytes_left_d  = bytes_left_q;
		length_size_d = length_size_q;
		start_size_d  = start_size_q;
		len_acc_d     = len_acc_q;
		start_acc_d   = start_acc_q;
		position_d    = position_q;
		halted_d      = halted_q;
		if (fire_s1) begin
			phase_d    = phase_e;
			position_d = pos_e;
			halted_d   = halted_e;
			if (!halted_e) begin
				unique case (phase_e)
					drld_pkg::PH_HEADER: begin
						if ((b == 8'd0) || bad_len || bad_st) begin
							halted_d = 1'b1;
						end else begin
							length_size_d = drld_pkg::CNT_W'(len_nib);
							start_size_d  = drld_pkg::CNT_W'(st_nib);
							bytes_left_d  = drld_pkg::CNT_W'(len_nib);
							len_acc_d     = '0;
							start_acc_d   = '0;
							phase_d       = drld_pkg::PH_LENGTH;
						end
					end
					drld_pkg::PH_LENGTH: begin
						len_acc_d    = len_acc_n;
						bytes_left_d = bytes_left_q - drld_pkg::CNT_W'(1);
						if (last_byte) begin
							bytes_left_d = start_size_q;
							phase_d      = drld_pkg::PH_START;
						end
					end
					drld_pkg::PH_START: begin
						start_acc_d  = start_acc_n;
						bytes_left_d = bytes_left_q - drld_pkg::CNT_W'(1);
						if (last_byte) begin
							phase_d = drld_pkg::PH_HEADER;
							if (rel_q && pos_neg) begin
								halted_d = 1'b1;
							end else begin
								position_d = new_start;
							end
						end
					end
					default: begin
						phase_d = drld_pkg::PH_HEADER;
					end
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Result of the byte in s1
	// ------------------------------------------------------------------
	always_comb begin
		res_valid  = 1'b0;
		res_status = drld_pkg::ST_RUN;
		res_start  = '0;
		res_len    = '0;
		if (!halted_e) begin
			unique case (phase_e)
				drld_pkg::PH_HEADER: begin
					priority if (b == 8'd0) begin
						res_valid  = 1'b1;
						res_status = drld_pkg::ST_END;
					end else if (bad_len) begin
						res_valid  = 1'b1;
						res_status = drld_pkg::ST_BAD_LEN;
					end else if (bad_st) begin
						res_valid  = 1'b1;
						res_status = drld_pkg::ST_BAD_START;
					end else begin
						res_valid = 1'b0;
					end
				end
				drld_pkg::PH_START: begin
					if (last_byte) begin
						res_valid = 1'b1;
						if (rel_q && pos_neg) begin
							res_status = drld_pkg::ST_NEGATIVE;
						end else begin
							res_status = drld_pkg::ST_RUN;
							res_start  = new_start;
							res_len    = run_len;
						end
					end
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Last cluster: start + length - 1, held at start for an empty run and
	// saturated at the top position on carry out
	// ------------------------------------------------------------------
	assign last_sum = (drld_pkg::POSITION_BITS + 1)'(start_s2)
	                + (drld_pkg::POSITION_BITS + 1)'(lenm1_s2);

	always_comb begin
		if (len_s2 == '0) begin
			run_last = start_s2;
		end else if (last_sum[drld_pkg::POSITION_BITS]) begin
			run_last = '1;
		end else begin
			run_last = last_sum[drld_pkg::POSITION_BITS-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			out_valid_q   <= 1'b0;
			rel_q         <= 1'b1;
			phase_q       <= drld_pkg::PH_HEADER;
			bytes_left_q  <= '0;
			length_size_q <= '0;
			start_size_q  <= '0;
			len_acc_q     <= '0;
			start_acc_q   <= '0;
			position_q    <= '0;
			halted_q      <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (adv_s2) begin
				v_s2 <= fire_s1 && res_valid;
			end
			if (adv_out) begin
				out_valid_q <= v_s2;
			end
			if (cfg_we) begin
				rel_q <= cfg_wdata;
			end
			phase_q       <= phase_d;
			bytes_left_q  <= bytes_left_d;
			length_size_q <= length_size_d;
			start_size_q  <= start_size_d;
			len_acc_q     <= len_acc_d;
			start_acc_q   <= start_acc_d;
			position_q    <= position_d;
			halted_q      <= halted_d;
		end
	end

	// Payload registers: load on advance, no reset
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_s1 <= in_data;
		end
		if (adv_s2) begin
			status_s2 <= res_status;
			start_s2  <= res_start;
			len_s2    <= res_len;
			if (res_status == drld_pkg::ST_RUN) begin
				lenm1_s2 <= run_len - drld_pkg::RUN_LEN_W'(1);
			end else begin
				lenm1_s2 <= '0;
			end
		end
		if (adv_out) begin
			out_q.status     <= status_s2;
			out_q.run_start  <= drld_pkg::RUN_START_W'(start_s2);
			out_q.run_length <= len_s2;
			out_q.run_last   <= drld_pkg::RUN_START_W'(run_last);
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// A halted list must not produce a result until the next list start
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && halted_q && !in_s1.list_start) |=> !v_s2)
		else $error("result produced while halted");

	// Inside a run there is always at least one byte still to come
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != drld_pkg::PH_HEADER) |-> (bytes_left_q != '0))
		else $error("field phase with no bytes left");

	// The last cluster never lies before the first
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.status == drld_pkg::ST_RUN))
		|-> (out_q.run_last >= out_q.run_start))
		else $error("run_last below run_start");

	// Events other than a decoded run carry no cluster numbers
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.status != drld_pkg::ST_RUN))
		|-> ((out_q.run_start == '0) && (out_q.run_length == '0) && (out_q.run_last == '0)))
		else $error("non-run result with non-zero fields");

endmodule

### bench/drld_run_checker.sv
`timescale 1ns / 1ps

module drld_run_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_ready,
	input  drld_pkg::in_t  in_data,
	input  logic           out_valid,
	input  logic           out_ready,
	input  drld_pkg::out_t out_data,
	input  logic           cfg_we,
	input  logic           cfg_wdata,
	output int             fail_count,
	output int             runs_due,
	output int             runs_seen
);

	localparam logic [63:0] POS_MASK = (64'd1 << drld_pkg::POSITION_BITS) - 64'd1;

	logic                               rel_mode;
	drld_pkg::phase_t                   phase;
	logic [3:0]                         bytes_left;
	logic [3:0]                         len_bytes;
	logic [3:0]                         start_bytes;
	logic [31:0]                        len_acc;
	logic [31:0]                        start_acc;
	logic [drld_pkg::POSITION_BITS-1:0] position;
	logic                               halted;

	drld_pkg::out_t expected_runs[$];

	task automatic report_mismatch(input string what);
		$display("%0t ns  result %0d: %s", $realtime, runs_seen, what);
		fail_count++;
	endtask

	function automatic drld_pkg::out_t list_event(input drld_pkg::status_t code);
		drld_pkg::out_t ev;
		ev = '0;
		ev.status = code;
		return ev;
	endfunction

	// Close a run once its last start byte is in: resolve the start and the end cluster.
	function automatic drld_pkg::out_t settle_run();
		drld_pkg::out_t res;
		logic [63:0]    delta;
		logic [63:0]    mag;
		logic [63:0]    s;
		logic [63:0]    len;
		logic [63:0]    last_c;
		int             bits;
		res = '0;
		len = 64'(len_acc);
		bits = int'(start_bytes) * 8;
		phase = drld_pkg::PH_HEADER;
		if (rel_mode) begin
			delta = 64'(start_acc);
			if (start_acc[bits-1])
				delta = delta | ~((64'd1 << bits) - 64'd1);
			if (delta[63]) begin
				mag = -delta;
				if (mag > 64'(position)) begin
					halted = 1'b1;
					return list_event(drld_pkg::ST_NEGATIVE);
				end
				s = 64'(position) - mag;
			end else begin
				s = (64'(position) + delta) & POS_MASK;
			end
		end else begin
			s = 64'(start_acc) & POS_MASK;
		end
		position = s[drld_pkg::POSITION_BITS-1:0];
		if (len == 64'd0)
			last_c = s;
		else if (len - 64'd1 > POS_MASK - s)
			last_c = POS_MASK;
		else
			last_c = s + len - 64'd1;
		res.status = drld_pkg::ST_RUN;
		res.run_start = s[drld_pkg::RUN_START_W-1:0];
		res.run_length = len_acc;
		res.run_last = last_c[drld_pkg::RUN_START_W-1:0];
		return res;
	endfunction

	task automatic decode_byte(input drld_pkg::in_t req);
		logic [7:0] b;
		logic [3:0] lo;
		logic [3:0] hi;
		b = req.data_byte;
		lo = b[3:0];
		hi = b[7:4];
		if (req.list_start) begin
			position = '0;
			halted = 1'b0;
			phase = drld_pkg::PH_HEADER;
		end
		if (halted)
			return;
		case (phase)
			drld_pkg::PH_HEADER: begin
				if (b == 8'd0) begin
					halted = 1'b1;
					expected_runs.push_back(list_event(drld_pkg::ST_END));
				end else if (lo == 4'd0 || lo > drld_pkg::MAX_FIELD_BYTES) begin
					halted = 1'b1;
					expected_runs.push_back(list_event(drld_pkg::ST_BAD_LEN));
				end else if (hi == 4'd0 || hi > drld_pkg::MAX_FIELD_BYTES) begin
					halted = 1'b1;
					expected_runs.push_back(list_event(drld_pkg::ST_BAD_START));
				end else begin
					len_bytes = lo;
					start_bytes = hi;
					len_acc = '0;
					start_acc = '0;
					bytes_left = lo;
					phase = drld_pkg::PH_LENGTH;
				end
			end
			drld_pkg::PH_LENGTH: begin
				len_acc = len_acc | (32'(b) << (8 * (len_bytes - bytes_left)));
				bytes_left--;
				if (bytes_left == 4'd0) begin
					bytes_left = start_bytes;
					phase = drld_pkg::PH_START;
				end
			end
			default: begin
				start_acc = start_acc | (32'(b) << (8 * (start_bytes - bytes_left)));
				bytes_left--;
				if (bytes_left == 4'd0)
					expected_runs.push_back(settle_run());
			end
		endcase
	endtask

	task automatic check_result(input drld_pkg::out_t got);
		drld_pkg::out_t want;
		runs_seen++;
		if (expected_runs.size() == 0) begin
			report_mismatch($sformatf("unexpected result, status %0d start %0h",
				got.status, got.run_start));
			return;
		end
		want = expected_runs.pop_front();
		if (got.status !== want.status)
			report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
		if (got.run_start !== want.run_start)
			report_mismatch($sformatf("run_start %0h, want %0h", got.run_start, want.run_start));
		if (got.run_length !== want.run_length)
			report_mismatch($sformatf("run_length %0h, want %0h",
				got.run_length, want.run_length));
		if (got.run_last !== want.run_last)
			report_mismatch($sformatf("run_last %0h, want %0h", got.run_last, want.run_last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_mode = 1'b1;
			phase = drld_pkg::PH_HEADER;
			bytes_left = '0;
			len_bytes = '0;
			start_bytes = '0;
			len_acc = '0;
			start_acc = '0;
			position = '0;
			halted = 1'b0;
			expected_runs.delete();
			fail_count = 0;
			runs_seen = 0;
		end else begin
			if (cfg_we)
				rel_mode = cfg_wdata;
			if (out_valid && out_ready)
				check_result(out_data);
			if (in_valid && in_ready)
				decode_byte(in_data);
		end
		runs_due = expected_runs.size();
	end

endmodule

### bench/data_run_list_decoder_core_tb.sv
`timescale 1ns / 1ps

module data_run_list_decoder_core_tb;

	localparam int CYCLE_LIMIT  = 1_000_000;
	// Two pipeline stages behind the input register, plus margin
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_ITEMS  = 250;
	localparam int HOLD_AFTER   = 400;
	localparam int HOLD_CYCLES  = 300;

	logic           clk;
	logic           arst_n    = 1'b0;
	logic           in_valid  = 1'b0;
	logic           in_ready;
	drld_pkg::in_t  in_data   = '0;
	logic           out_valid;
	logic           out_ready = 1'b0;
	drld_pkg::out_t out_data;
	logic           cfg_we    = 1'b0;
	logic           cfg_wdata = 1'b0;

	int fail_count;
	int runs_due;
	int runs_seen;
	int cycles       = 0;
	int bytes_sent   = 0;
	int phase_items  = 0;
	int mode_writes  = 0;
	bit no_idle      = 1'b0;
	bit relative_now = 1'b1;

	data_run_list_decoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Watches both channels and the mode register, predicts every result and compares
	drld_run_checker run_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.runs_due   (runs_due),
		.runs_seen  (runs_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Abandon the run if it hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Idle length: mostly none or short, now and then long; none at all in a quiet stretch
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Result side: random back-pressure, and once a long hold-off so the pipeline
	// fills and in_ready drops while bytes are still being offered.
	initial begin : receiver
		int stall;
		int hold_left;
		bit hold_done;
		stall = 0;
		hold_left = 0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (!hold_done && bytes_sent >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	// Offer one request, optionally after an idle gap, and hold it until taken.
	// Returns at the edge that accepted it, so valid may stay high for the next one.
	task automatic send_req(input logic [7:0] b, input logic start_flag, input bit counted);
		drld_pkg::in_t req;
		int            gap;
		req.data_byte = b;
		req.list_start = start_flag;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do
			@(posedge clk);
		while (!in_ready);
		bytes_sent++;
		if (counted)
			phase_items++;
	endtask

	// Drop valid and wait until every predicted result is out and the pipe has drained
	task automatic settle_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (runs_due != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic rel);
		settle_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= rel;
		@(posedge clk);
		cfg_we <= 1'b0;
		relative_now = rel;
		mode_writes++;
	endtask

	// One run: header and body with random sizes and content; keep cuts the body short.
	task automatic send_run(input bit first, input bit counted, input int keep);
		logic [3:0] lsz;
		logic [3:0] ssz;
		logic [7:0] body [8];
		bit         zero_len;
		int         n;
		int         i;
		lsz = 4'($urandom_range(1, drld_pkg::MAX_FIELD_BYTES));
		ssz = 4'($urandom_range(1, drld_pkg::MAX_FIELD_BYTES));
		zero_len = ($urandom_range(0, 7) == 0);
		n = lsz + ssz;
		for (i = 0; i < n; i++)
			body[i] = (zero_len && i < lsz) ? 8'd0 : 8'($urandom);
		// Mostly forward deltas, so lists get past their first run in relative mode
		if (relative_now && $urandom_range(0, 9) < 7)
			body[n-1][7] = 1'b0;
		send_req({ssz, lsz}, first, counted);
		for (i = 0; i < n && i < keep; i++)
			send_req(body[i], 1'b0, counted);
	endtask

	function automatic logic [7:0] bad_header();
		logic [3:0] good;
		logic [3:0] bad;
		good = 4'($urandom_range(1, drld_pkg::MAX_FIELD_BYTES));
		bad = ($urandom_range(0, 2) == 0) ? 4'd0
			: 4'($urandom_range(drld_pkg::MAX_FIELD_BYTES + 1, 15));
		case ($urandom_range(0, 2))
			0:       return {good, bad};
			1:       return {bad, good};
			default: return {bad, bad};
		endcase
	endfunction

	task automatic send_list();
		int kind;
		int runs;
		int i;
		kind = $urandom_range(0, 9);
		no_idle = ($urandom_range(0, 5) == 0);
		if (kind <= 6) begin
			// Well-formed list, usually closed by a zero header
			runs = $urandom_range(1, 6);
			for (i = 0; i < runs; i++)
				send_run(i == 0, 1'b1, 99);
			if ($urandom_range(0, 9) < 7)
				send_req(8'h00, 1'b0, 1'b1);
		end else if (kind == 7) begin
			// Noise: raw bytes with the odd list start among them
			runs = $urandom_range(1, 8);
			for (i = 0; i < runs; i++)
				send_req(8'($urandom), $urandom_range(0, 3) == 0, 1'b0);
		end else if (kind == 8) begin
			// Broken list: the second run may be cut off before the next list starts
			send_run(1'b1, 1'b1, 99);
			send_run(1'b0, 1'b1, $urandom_range(0, 7));
		end else begin
			send_req(bad_header(), 1'b1, 1'b1);
		end
	endtask

	initial begin : stimulus
		int ph;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Relative mode straight out of reset: a short run at cluster 5
		send_req(8'h11, 1'b1, 1'b0);
		send_req(8'hFF, 1'b0, 1'b0);
		send_req(8'h05, 1'b0, 1'b0);
		// Widest fields: largest length, largest forward delta
		send_req(8'h44, 1'b0, 1'b0);
		repeat (4) send_req(8'hFF, 1'b0, 1'b0);
		send_req(8'hFF, 1'b0, 1'b0);
		send_req(8'hFF, 1'b0, 1'b0);
		send_req(8'hFF, 1'b0, 1'b0);
		send_req(8'h7F, 1'b0, 1'b0);
		// Zero length, stepping back 128 clusters
		send_req(8'h11, 1'b0, 1'b0);
		send_req(8'h00, 1'b0, 1'b0);
		send_req(8'h80, 1'b0, 1'b0);
		// Fresh list stepping below zero halts it; the next byte is dropped
		send_req(8'h11, 1'b1, 1'b0);
		send_req(8'h01, 1'b0, 1'b0);
		send_req(8'hFF, 1'b0, 1'b0);
		send_req(8'h22, 1'b0, 1'b0);
		// End of list at once, then each kind of bad header
		send_req(8'h00, 1'b1, 1'b0);
		send_req(8'h05, 1'b1, 1'b0);
		send_req(8'h10, 1'b1, 1'b0);
		send_req(8'h01, 1'b1, 1'b0);
		send_req(8'h51, 1'b1, 1'b0);

		// Absolute mode: the largest unsigned start
		write_mode(1'b0);
		send_req(8'h41, 1'b1, 1'b0);
		send_req(8'h01, 1'b0, 1'b0);
		repeat (4) send_req(8'hFF, 1'b0, 1'b0);

		// Random phases, alternating the offset mode
		for (ph = 0; ph < 4; ph++) begin
			write_mode(ph[0] ? 1'b0 : 1'b1);
			phase_items = 0;
			while (phase_items < PHASE_ITEMS)
				send_list();
		end

		no_idle = 1'b0;
		settle_idle();
		$display("%0d results checked from %0d bytes, %0d mode writes",
			runs_seen, bytes_sent, mode_writes);
		$display("relative and absolute offsets, bad headers, halts, cut lists, output hold-off");
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### filelist.f
rtl/drld_pkg.sv
rtl/data_run_list_decoder_core.sv
bench/drld_run_checker.sv
bench/data_run_list_decoder_core_tb.sv
